@@ rtl/reversible_deque_unit_macros.svh @@
// assertion macros for the reversible deque unit
`ifndef REVERSIBLE_DEQUE_UNIT_MACROS_SVH
`define REVERSIBLE_DEQUE_UNIT_MACROS_SVH

// property checked on every clock edge outside reset
`define RDQ_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// implication where the consequent is checked in the cycle after the antecedent
`define RDQ_ASSERT_NEXT(label, ante, cons, msg) \
  `RDQ_ASSERT(label, (ante) |=> (cons), msg)

`endif

@@ rtl/rdq_pkg.sv @@
// shared types and constants of the reversible deque unit
`default_nettype none

package rdq_pkg;

  localparam int RDQ_DEPTH  = 1024;
  localparam int RDQ_WORD_W = 32;
  localparam int RDQ_OP_W   = 3;
  localparam int RDQ_ST_W   = 2;

  typedef enum logic [RDQ_OP_W-1:0] {
    OP_POP_BACK   = 3'd0,
    OP_POP_FRONT  = 3'd1,
    OP_REVERSE    = 3'd2,
    OP_PUSH_BACK  = 3'd3,
    OP_PUSH_FRONT = 3'd4
  } rdq_op_e;

  typedef enum logic [RDQ_ST_W-1:0] {
    ST_DATA  = 2'd0,
    ST_EMPTY = 2'd1,
    ST_DONE  = 2'd2,
    ST_FULL  = 2'd3
  } rdq_status_e;

  typedef struct packed {
    logic load;
    logic exec;
  } rdq_cmd_t;

endpackage

`default_nettype wire

@@ rtl/reversible_deque_unit.sv @@
// top level of the reversible deque unit
`default_nettype none
`include "reversible_deque_unit_macros.svh"

// Reversible deque of signed 32-bit words in a circular buffer of DEPTH entries.
// A transaction is taken when start_i is high and busy_o is low; busy_o then stays
// high for one cycle while the controller runs the operation on the datapath (one
// storage access plus the pointer update), and a new one can be started as soon as
// busy_o drops. Its result appears on status_o and data_o for exactly one cycle with
// result_valid_o high, in the first cycle with busy_o low again; the receiver cannot
// stall it and must take it then. The storage needs no clearing pass after reset,
// since a pop only reads occupied entries.

module reversible_deque_unit
  import rdq_pkg::*;
#(
  parameter int DEPTH = RDQ_DEPTH
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         start_i,
  output logic                              busy_o,
  input  wire logic        [RDQ_OP_W-1:0]   op_i,
  input  wire logic signed [RDQ_WORD_W-1:0] value_i,
  output logic                              result_valid_o,
  output logic             [RDQ_ST_W-1:0]   status_o,
  output logic signed      [RDQ_WORD_W-1:0] data_o
);

  rdq_cmd_t cmd;

  rdq_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .cmd_o          (cmd),
    .busy_o         (busy_o),
    .result_valid_o (result_valid_o)
  );

  rdq_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (cmd),
    .op_i     (op_i),
    .value_i  (value_i),
    .status_o (status_o),
    .data_o   (data_o)
  );

  `RDQ_ASSERT_NEXT(a_accept_busy, start_i && !busy_o, busy_o && !result_valid_o, "accepted transaction did not start execution")
  `RDQ_ASSERT(a_result_after_exec, result_valid_o |-> $past(busy_o), "result without preceding execution")
  `RDQ_ASSERT(a_data_zero, result_valid_o && (status_o != ST_DATA) |-> (data_o == '0), "nonzero data without pop")
  `RDQ_ASSERT(a_no_overlap, busy_o |-> !result_valid_o, "result strobe while executing")

endmodule

`default_nettype wire

@@ rtl/rdq_ctrl.sv @@
// controller state machine of the reversible deque unit
`default_nettype none

module rdq_ctrl
  import rdq_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     start_i,
  output rdq_cmd_t      cmd_o,
  output logic          busy_o,
  output logic          result_valid_o
);

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_e;

  state_e state_q;
  logic   valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      valid_q <= 1'b0;
    end else begin
      case (state_q)
        S_IDLE: begin
          valid_q <= 1'b0;
          if (start_i) begin
            state_q <= S_EXEC;
          end
        end
        S_EXEC: begin
          valid_q <= 1'b1;
          state_q <= S_IDLE;
        end
        default: begin
          valid_q <= 1'b0;
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign cmd_o.load     = (state_q == S_IDLE) && start_i;
  assign cmd_o.exec     = (state_q == S_EXEC);
  assign busy_o         = (state_q == S_EXEC);
  assign result_valid_o = valid_q;

endmodule

`default_nettype wire

@@ rtl/rdq_dp.sv @@
// datapath of the reversible deque unit: storage, pointers, reverse flag, result
`default_nettype none

module rdq_dp
  import rdq_pkg::*;
#(
  parameter int DEPTH = RDQ_DEPTH
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire rdq_cmd_t                     cmd_i,
  input  wire logic        [RDQ_OP_W-1:0]   op_i,
  input  wire logic signed [RDQ_WORD_W-1:0] value_i,
  output logic             [RDQ_ST_W-1:0]   status_o,
  output logic signed      [RDQ_WORD_W-1:0] data_o
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam int SW = PW + 1;

  logic [RDQ_WORD_W-1:0] mem [DEPTH];

  logic [RDQ_OP_W-1:0]   op_q;
  logic [RDQ_WORD_W-1:0] value_q;
  logic [PW-1:0]         head_q, head_d;
  logic [CW-1:0]         cnt_q, cnt_d;
  logic                  rev_q, rev_d;
  logic [RDQ_WORD_W-1:0] rd_q;
  logic [RDQ_ST_W-1:0]   status_q;
  logic                  take_q;

  logic [SW-1:0]         tail_sum, put_sum, inc_sum;
  logic [PW-1:0]         tail_idx, put_idx, head_inc, head_dec;
  logic                  empty, full, from_tail, to_tail;
  logic                  wr_en, rd_en, take;
  logic [PW-1:0]         wr_addr, rd_addr;
  rdq_status_e           status;

  // circular index arithmetic, sums stay below twice the depth
  assign tail_sum = SW'(head_q) + SW'(cnt_q) - SW'(1);
  assign put_sum  = SW'(head_q) + SW'(cnt_q);
  assign inc_sum  = SW'(head_q) + SW'(1);
  assign tail_idx = (tail_sum >= SW'(DEPTH)) ? PW'(tail_sum - SW'(DEPTH)) : PW'(tail_sum);
  assign put_idx  = (put_sum >= SW'(DEPTH)) ? PW'(put_sum - SW'(DEPTH)) : PW'(put_sum);
  assign head_inc = (inc_sum >= SW'(DEPTH)) ? PW'(inc_sum - SW'(DEPTH)) : PW'(inc_sum);
  assign head_dec = (head_q == '0) ? PW'(DEPTH - 1) : head_q - PW'(1);

  assign empty     = (cnt_q == '0);
  assign full      = (cnt_q == CW'(DEPTH));
  assign from_tail = (op_q == OP_POP_BACK) ^ rev_q;
  assign to_tail   = (op_q == OP_PUSH_BACK) ^ rev_q;

  always_comb begin
    head_d  = head_q;
    cnt_d   = cnt_q;
    rev_d   = rev_q;
    wr_en   = 1'b0;
    rd_en   = 1'b0;
    take    = 1'b0;
    wr_addr = put_idx;
    rd_addr = tail_idx;
    status  = ST_DONE;
    case (rdq_op_e'(op_q))
      OP_POP_BACK, OP_POP_FRONT: begin
        if (empty) begin
          status = ST_EMPTY;
        end else begin
          status = ST_DATA;
          take   = 1'b1;
          rd_en  = 1'b1;
          cnt_d  = cnt_q - CW'(1);
          if (!from_tail) begin
            rd_addr = head_q;
            head_d  = head_inc;
          end
        end
      end
      OP_REVERSE: begin
        rev_d = ~rev_q;
      end
      OP_PUSH_BACK, OP_PUSH_FRONT: begin
        if (full) begin
          status = ST_FULL;
        end else begin
          wr_en = 1'b1;
          cnt_d = cnt_q + CW'(1);
          if (!to_tail) begin
            wr_addr = head_dec;
            head_d  = head_dec;
          end
        end
      end
      default: begin
        status = ST_DONE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0;
      cnt_q  <= '0;
      rev_q  <= 1'b0;
    end else if (cmd_i.exec) begin
      head_q <= head_d;
      cnt_q  <= cnt_d;
      rev_q  <= rev_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q    <= op_i;
      value_q <= value_i;
    end
    if (cmd_i.exec) begin
      status_q <= status;
      take_q   <= take;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec && wr_en) begin
      mem[wr_addr] <= value_q;
    end
    if (cmd_i.exec && rd_en) begin
      rd_q <= mem[rd_addr];
    end
  end

  assign status_o = status_q;
  assign data_o   = take_q ? rd_q : '0;

endmodule

`default_nettype wire

@@ sim/reversible_deque_unit_test.sv @@
// self-checking testbench for the reversible deque unit
`timescale 1ns / 1ps

module reversible_deque_unit_test;
  import rdq_pkg::*;

  localparam logic [RDQ_OP_W-1:0] OP_SPARE_5 = 3'd5;
  localparam logic [RDQ_OP_W-1:0] OP_SPARE_6 = 3'd6;
  localparam logic [RDQ_OP_W-1:0] OP_SPARE_7 = 3'd7;
  localparam int DIR_ROWS = 24;
  localparam int FILL_ITEMS = RDQ_DEPTH + 6;
  localparam int RAND_ITEMS = 950;
  localparam int STALL_LIMIT = 1000;
  localparam int MAX_REPORTS = 10;

  typedef struct packed {
    logic        [RDQ_OP_W-1:0]   op;
    logic        [RDQ_WORD_W-1:0] value;
    logic                         typed;
    rdq_status_e                  status;
    logic        [RDQ_WORD_W-1:0] data;
  } stim_row_t;

  typedef struct packed {
    rdq_status_e                  status;
    logic signed [RDQ_WORD_W-1:0] data;
  } deque_reply_t;

  logic                         clk_i = 1'b0;
  logic                         rst_ni = 1'b0;
  logic                         start_i = 1'b0;
  logic        [RDQ_OP_W-1:0]   op_i = '0;
  logic signed [RDQ_WORD_W-1:0] value_i = '0;
  logic                         busy_o;
  logic                         result_valid_o;
  logic        [RDQ_ST_W-1:0]   status_o;
  logic signed [RDQ_WORD_W-1:0] data_o;

  logic                    row_typed = 1'b0;
  rdq_status_e             row_status = ST_DATA;
  logic [RDQ_WORD_W-1:0]   row_data = '0;

  logic [RDQ_WORD_W-1:0]   model_mem [RDQ_DEPTH];
  int                      model_head = 0;
  int                      model_count = 0;
  bit                      model_rev = 1'b0;

  deque_reply_t            pending_replies [$];
  stim_row_t               dir_tab [DIR_ROWS];
  int                      bad_replies = 0;
  int                      taken_items = 0;
  int                      stall_cycles = 0;
  int                      n_data_pops = 0;
  int                      n_empty_pops = 0;
  int                      n_full_pushes = 0;
  int                      n_reverses = 0;

  reversible_deque_unit DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .op_i           (op_i),
    .value_i        (value_i),
    .result_valid_o (result_valid_o),
    .status_o       (status_o),
    .data_o         (data_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  function automatic deque_reply_t deque_apply_op(input logic [RDQ_OP_W-1:0] op,
                                                  input logic [RDQ_WORD_W-1:0] val);
    deque_reply_t r;
    bit           at_tail;
    r.status = ST_DONE;
    r.data   = '0;
    case (op)
      OP_POP_BACK, OP_POP_FRONT: begin
        if (model_count == 0) begin
          r.status = ST_EMPTY;
        end else begin
          at_tail = (op == OP_POP_BACK) ? !model_rev : model_rev;
          if (at_tail) begin
            r.data = model_mem[(model_head + model_count - 1) % RDQ_DEPTH];
          end else begin
            r.data = model_mem[model_head];
            model_head = (model_head + 1) % RDQ_DEPTH;
          end
          model_count--;
          r.status = ST_DATA;
        end
      end
      OP_REVERSE: model_rev = !model_rev;
      OP_PUSH_BACK, OP_PUSH_FRONT: begin
        if (model_count >= RDQ_DEPTH) begin
          r.status = ST_FULL;
        end else begin
          at_tail = (op == OP_PUSH_BACK) ? !model_rev : model_rev;
          if (at_tail) begin
            model_mem[(model_head + model_count) % RDQ_DEPTH] = val;
          end else begin
            model_head = (model_head == 0) ? RDQ_DEPTH - 1 : model_head - 1;
            model_mem[model_head] = val;
          end
          model_count++;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  always @(posedge clk_i) begin : reply_check
    deque_reply_t want;
    if (rst_ni) begin
      if (result_valid_o === 1'b1) begin
        if (pending_replies.size() == 0) begin
          if (bad_replies < MAX_REPORTS)
            $display("unexpected transaction: status %0d data %0d", status_o, data_o);
          bad_replies++;
        end else begin
          want = pending_replies[0];
          pending_replies.delete(0);
          if (status_o !== want.status || data_o !== want.data) begin
            if (bad_replies < MAX_REPORTS)
              $display("mismatch: expected status %0d data %0d, got status %0d data %0d",
                       want.status, want.data, status_o, data_o);
            bad_replies++;
          end
        end
      end
      if (start_i === 1'b1 && busy_o === 1'b0) begin
        want = deque_apply_op(op_i, value_i);
        if (row_typed) begin
          want.status = row_status;
          want.data   = row_data;
        end
        case (want.status)
          ST_DATA:  n_data_pops++;
          ST_EMPTY: n_empty_pops++;
          ST_FULL:  n_full_pushes++;
          default:  ;
        endcase
        if (op_i == OP_REVERSE) n_reverses++;
        pending_replies.insert(pending_replies.size(), want);
        taken_items++;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && start_i === 1'b1 && busy_o === 1'b0) stall_cycles <= 0;
    else if (rst_ni) stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  task automatic send_item(input logic [RDQ_OP_W-1:0] op, input logic [RDQ_WORD_W-1:0] val,
                           input logic typed, input rdq_status_e st,
                           input logic [RDQ_WORD_W-1:0] dat);
    start_i    <= 1'b1;
    op_i       <= op;
    value_i    <= val;
    row_typed  <= typed;
    row_status <= st;
    row_data   <= dat;
    do @(posedge clk_i); while (busy_o !== 1'b0);
  endtask

  task automatic maybe_gap(input bit calm);
    int cycles;
    cycles = $urandom_range(1, 4);
    if (!calm && $urandom_range(0, 3) == 0) begin
      start_i <= 1'b0;
      op_i    <= 3'($urandom);
      value_i <= $urandom;
      repeat (cycles) @(posedge clk_i);
    end
  endtask

  task automatic wait_drained();
    start_i <= 1'b0;
    do @(posedge clk_i); while (pending_replies.size() != 0);
  endtask

  initial begin
    logic [RDQ_OP_W-1:0] op;
    int                  pick;
    int                  push_bias;
    dir_tab = '{
      '{OP_POP_BACK,   32'h0000_0000, 1'b1, ST_EMPTY, 32'h0},
      '{OP_POP_FRONT,  32'h1234_5678, 1'b1, ST_EMPTY, 32'h0},
      '{OP_SPARE_5,    32'hFFFF_FFFF, 1'b1, ST_DONE,  32'h0},
      '{OP_SPARE_6,    32'h0000_0000, 1'b1, ST_DONE,  32'h0},
      '{OP_SPARE_7,    32'hA5A5_A5A5, 1'b1, ST_DONE,  32'h0},
      '{OP_REVERSE,    32'h0000_0000, 1'b1, ST_DONE,  32'h0},
      '{OP_POP_FRONT,  32'hFFFF_FFFF, 1'b1, ST_EMPTY, 32'h0},
      '{OP_REVERSE,    32'hFFFF_FFFF, 1'b1, ST_DONE,  32'h0},
      '{OP_PUSH_BACK,  32'h7FFF_FFFF, 1'b1, ST_DONE,  32'h0},
      '{OP_PUSH_FRONT, 32'h8000_0000, 1'b1, ST_DONE,  32'h0},
      '{OP_PUSH_BACK,  32'hFFFF_FFFF, 1'b1, ST_DONE,  32'h0},
      '{OP_POP_FRONT,  32'h0000_0000, 1'b0, ST_DATA,  32'h0},
      '{OP_REVERSE,    32'h0000_0000, 1'b1, ST_DONE,  32'h0},
      '{OP_POP_FRONT,  32'h5555_5555, 1'b0, ST_DATA,  32'h0},
      '{OP_PUSH_FRONT, 32'h0000_0000, 1'b1, ST_DONE,  32'h0},
      '{OP_PUSH_BACK,  32'h0000_0001, 1'b1, ST_DONE,  32'h0},
      '{OP_POP_BACK,   32'hAAAA_AAAA, 1'b0, ST_DATA,  32'h0},
      '{OP_REVERSE,    32'h0000_0000, 1'b1, ST_DONE,  32'h0},
      '{OP_POP_BACK,   32'h0000_0000, 1'b0, ST_DATA,  32'h0},
      '{OP_POP_BACK,   32'h0000_0000, 1'b0, ST_DATA,  32'h0},
      '{OP_POP_BACK,   32'hFFFF_FFFF, 1'b1, ST_EMPTY, 32'h0},
      '{OP_SPARE_7,    32'h5A5A_5A5A, 1'b1, ST_DONE,  32'h0},
      '{OP_PUSH_FRONT, 32'h5555_5555, 1'b1, ST_DONE,  32'h0},
      '{OP_POP_BACK,   32'h0000_0000, 1'b0, ST_DATA,  32'h0}
    };
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_tab[i]) begin
      maybe_gap(1'b0);
      send_item(dir_tab[i].op, dir_tab[i].value, dir_tab[i].typed,
                dir_tab[i].status, dir_tab[i].data);
    end
    wait_drained();

    // send six items more than the capacity, mostly pushes with an occasional reversal
    for (int i = 0; i < FILL_ITEMS; i++) begin
      maybe_gap(1'b0);
      pick = $urandom_range(0, 49);
      if (pick == 0) op = OP_REVERSE;
      else op = pick[0] ? OP_PUSH_BACK : OP_PUSH_FRONT;
      send_item(op, $urandom, 1'b0, ST_DATA, '0);
    end
    wait_drained();

    push_bias = 50;
    for (int i = 0; i < RAND_ITEMS; i++) begin
      if (i % 200 == 0) push_bias = $urandom_range(20, 80);
      maybe_gap(i >= RAND_ITEMS * 9 / 10);
      pick = $urandom_range(0, 99);
      if (pick < 5) op = OP_REVERSE;
      else if (pick < 8) op = 3'($urandom_range(OP_SPARE_5, OP_SPARE_7));
      else if ($urandom_range(0, 99) < push_bias)
        op = $urandom_range(0, 1) ? OP_PUSH_BACK : OP_PUSH_FRONT;
      else
        op = $urandom_range(0, 1) ? OP_POP_BACK : OP_POP_FRONT;
      send_item(op, $urandom, 1'b0, ST_DATA, '0);
    end

    wait_drained();
    repeat (8) @(posedge clk_i);
    $display("ran %0d transactions: %0d pops with data, %0d empty pops", taken_items,
             n_data_pops, n_empty_pops);
    $display("%0d dropped pushes on a full store, %0d reversals, %0d mismatches",
             n_full_pushes, n_reverses, bad_replies);
    if (bad_replies == 0 && pending_replies.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

@@ files.f @@
+incdir+rtl
rtl/rdq_pkg.sv
rtl/rdq_ctrl.sv
rtl/rdq_dp.sv
rtl/reversible_deque_unit.sv
sim/reversible_deque_unit_test.sv
